@@ rtl/tsppe_pkg.sv @@
// ----------------------------------------------------------------------------
// tsppe_pkg
// Shared types and constants of the transport stream payload extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package tsppe_pkg;

    localparam int BYTE_W     = 8;
    localparam int PID_W      = 13;
    localparam int FMT_W      = 2;
    localparam int POS_W      = 8;
    localparam int CFG_IDX_W  = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_PID  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_FORMAT = 1'd1;

    // unit formats
    localparam logic [FMT_W-1:0] FMT_188 = 2'd0;
    localparam logic [FMT_W-1:0] FMT_192 = 2'd1;
    localparam logic [FMT_W-1:0] FMT_204 = 2'd2;

    localparam logic [POS_W-1:0] LAST_188    = 8'd187;
    localparam logic [POS_W-1:0] LAST_192    = 8'd191;
    localparam logic [POS_W-1:0] LAST_204    = 8'd203;
    localparam logic [POS_W-1:0] PREFIX_192  = 8'd4;
    localparam logic [POS_W-1:0] PACKET_LEN  = 8'd188;

    // header byte positions within a packet
    localparam logic [POS_W-1:0] HDR_PID_HI  = 8'd1;
    localparam logic [POS_W-1:0] HDR_PID_LO  = 8'd2;
    localparam logic [POS_W-1:0] HDR_CTRL    = 8'd3;
    localparam logic [POS_W-1:0] HDR_ADAPT   = 8'd4;

    localparam logic [4:0] PID_HI_MASK = 5'h1f;

    typedef struct packed {
        logic [PID_W-1:0] target_pid;
        logic [FMT_W-1:0] unit_format;
        logic             pid_write;
    } cfg_t;

    typedef struct packed {
        logic unit_started;
    } stat_t;

endpackage

`default_nettype wire

@@ rtl/tsppe_in_stage.sv @@
// ----------------------------------------------------------------------------
// tsppe_in_stage
// Input register: holds one stream byte until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tsppe_in_stage (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [tsppe_pkg::BYTE_W-1:0] s_tdata,    // [7:0] stream_byte
    output logic                         in_valid,
    output logic [tsppe_pkg::BYTE_W-1:0] in_byte,
    input  wire                          in_take
);
    import tsppe_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    assign s_tready = !valid_reg || in_take;
    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tsppe_parser.sv @@
// ----------------------------------------------------------------------------
// tsppe_parser
// Packet position tracking, header parse, PID filter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tsppe_parser (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  tsppe_pkg::cfg_t              cfg,
    input  wire                          in_valid,
    input  wire  [tsppe_pkg::BYTE_W-1:0] in_byte,
    output logic                         in_take,
    output tsppe_pkg::stat_t             stat,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [tsppe_pkg::BYTE_W-1:0] m_tdata,    // [7:0] payload_byte
    output logic [0:0]                   m_tuser,    // [0] unit_begin
    output logic                         m_tlast     // packet_end
);
    import tsppe_pkg::*;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [4:0]        pid_hi_reg, pid_hi_next;
    logic              start_flag_reg, start_flag_next;
    logic              pid_match_reg, pid_match_next;
    logic [1:0]        fctl_reg, fctl_next;
    logic [POS_W-1:0]  adapt_reg, adapt_next;
    logic              started_reg, started_next;
    logic              pending_reg, pending_next;

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_begin_reg, out_begin_next;
    logic              out_end_reg, out_end_next;

    logic              fire;
    logic [POS_W-1:0]  last_pos;
    logic [POS_W-1:0]  skip;
    logic [POS_W-1:0]  p;
    logic              in_pkt;
    logic              pid_hit;

    assign in_take  = !out_valid_reg || m_tready;
    assign fire     = in_valid && in_take;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_begin_reg;
    assign m_tlast  = out_end_reg;
    assign stat.unit_started = started_reg;

    always_comb begin
        case (cfg.unit_format)
            FMT_192: begin
                last_pos = LAST_192;
                skip     = PREFIX_192;
            end
            FMT_204: begin
                last_pos = LAST_204;
                skip     = '0;
            end
            default: begin
                last_pos = LAST_188;
                skip     = '0;
            end
        endcase
    end

    assign p       = pos_reg - skip;
    assign in_pkt  = (pos_reg >= skip) && (p < PACKET_LEN);
    assign pid_hit = ({pid_hi_reg, in_byte} == cfg.target_pid);

    always_comb begin
        pos_next        = pos_reg;
        pid_hi_next     = pid_hi_reg;
        start_flag_next = start_flag_reg;
        pid_match_next  = pid_match_reg;
        fctl_next       = fctl_reg;
        adapt_next      = adapt_reg;
        started_next    = started_reg;
        pending_next    = pending_reg;
        out_byte_next   = out_byte_reg;
        out_begin_next  = out_begin_reg;
        out_end_next    = out_end_reg;
        out_valid_next  = out_valid_reg && !m_tready;

        if (cfg.pid_write) begin
            started_next = 1'b0;
            pending_next = 1'b0;
        end

        if (fire) begin
            if (in_pkt) begin
                if (p == HDR_PID_HI) begin
                    pid_hi_next     = in_byte[4:0] & PID_HI_MASK;
                    start_flag_next = in_byte[6];
                end else if (p == HDR_PID_LO) begin
                    pid_match_next = pid_hit;
                    if (pid_hit && start_flag_reg) begin
                        started_next = 1'b1;
                        pending_next = 1'b1;
                    end else begin
                        pending_next = 1'b0;
                    end
                end else if (p == HDR_CTRL) begin
                    fctl_next  = in_byte[5:4];
                    adapt_next = '0;
                end else if (p == HDR_ADAPT && fctl_reg[1]) begin
                    adapt_next = in_byte;
                end else if (p >= HDR_ADAPT) begin
                    if (adapt_reg != '0) begin
                        adapt_next = adapt_reg - 8'd1;
                    end else if (fctl_reg[0] && pid_match_reg && started_reg) begin
                        out_valid_next = 1'b1;
                        out_byte_next  = in_byte;
                        out_begin_next = pending_reg;
                        out_end_next   = (p == LAST_188);
                        pending_next   = 1'b0;
                    end
                end
            end
            pos_next = (pos_reg >= last_pos) ? '0 : pos_reg + 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            pid_hi_reg     <= '0;
            start_flag_reg <= 1'b0;
            pid_match_reg  <= 1'b0;
            fctl_reg       <= '0;
            adapt_reg      <= '0;
            started_reg    <= 1'b0;
            pending_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            pid_hi_reg     <= pid_hi_next;
            start_flag_reg <= start_flag_next;
            pid_match_reg  <= pid_match_next;
            fctl_reg       <= fctl_next;
            adapt_reg      <= adapt_next;
            started_reg    <= started_next;
            pending_reg    <= pending_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg  <= out_byte_next;
        out_begin_reg <= out_begin_next;
        out_end_reg   <= out_end_next;
    end

endmodule

`default_nettype wire

@@ rtl/ts_packet_payload_extractor_top.sv @@
// ----------------------------------------------------------------------------
// ts_packet_payload_extractor_top
// Transport stream PID filter passing payload bytes of one selected PID.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock when not stalled and passes on the payload
// bytes of packets whose PID equals target_pid, once a unit-start packet of
// that PID has been seen. A beat is parsed while it sits in the input
// register and its result is loaded into the output register when the parser
// takes it. Throughput is one byte per clock while the output is not stalled,
// set by the single parse stage; backpressure on the master side stalls the
// input only when the output register is still full.
// Configuration writes are taken every cycle and must be issued only while
// the block is idle; writing target_pid requires a new unit-start packet
// before payload flows again.
`default_nettype none

module ts_packet_payload_extractor_top (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire  [tsppe_pkg::BYTE_W-1:0]    s_tdata,    // [7:0] stream_byte
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [tsppe_pkg::BYTE_W-1:0]    m_tdata,    // [7:0] payload_byte
    output logic [0:0]                      m_tuser,    // [0] unit_begin
    output logic                            m_tlast,    // packet_end
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire  [tsppe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [tsppe_pkg::PID_W-1:0]     cfg_data
);
    import tsppe_pkg::*;

    logic [PID_W-1:0]  target_pid_reg, target_pid_next;
    logic [FMT_W-1:0]  unit_format_reg, unit_format_next;
    logic              pid_write;
    cfg_t              cfg;
    stat_t             stat;
    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              in_take;

    assign cfg_ready = 1'b1;

    always_comb begin
        target_pid_next  = target_pid_reg;
        unit_format_next = unit_format_reg;
        pid_write        = 1'b0;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_TARGET_PID: begin
                    target_pid_next = cfg_data;
                    pid_write       = 1'b1;
                end
                REG_UNIT_FORMAT: begin
                    unit_format_next = cfg_data[FMT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_pid_reg  <= '0;
            unit_format_reg <= FMT_188;
        end else begin
            target_pid_reg  <= target_pid_next;
            unit_format_reg <= unit_format_next;
        end
    end

    assign cfg.target_pid  = target_pid_reg;
    assign cfg.unit_format = unit_format_reg;
    assign cfg.pid_write   = pid_write;

    tsppe_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .in_take  (in_take)
    );

    tsppe_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .in_take  (in_take),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_pid_write_clears_start : assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready && cfg_index == REG_TARGET_PID) |=> !stat.unit_started)
        else $error("unit start not cleared after target_pid write");

    a_output_needs_start : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> stat.unit_started || $past(cfg_valid && cfg_index == REG_TARGET_PID))
        else $error("payload beat without a seen unit start");

    a_output_from_input : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(in_valid))
        else $error("result beat without a parsed input beat");

    a_accept_when_drained : assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled while output side is free");

endmodule

`default_nettype wire
